// ===== src/mvsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared types and constants for the multi-voice sample mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

    localparam int NUM_VOICES   = 8;
    localparam int SAMPLE_WORDS = 65536;
    localparam int SAMPLE_AW    = $clog2(SAMPLE_WORDS);
    localparam int VOICE_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_AW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    // Operation codes as they arrive on the operation port.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef struct packed {
        op_t                kind;
        logic [15:0]        addr;
        logic signed [15:0] value;
        logic [15:0]        frames;
        logic               stereo;
        logic [17:0]        rate;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_RD1,
        ST_RD2,
        ST_OUT
    } eng_state_t;

endpackage
`default_nettype wire

// ===== src/mvsm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mvsm_front
// Input register: takes an item from the command port, decodes its operation
// and hands it to the command queue as soon as there is room.
// ----------------------------------------------------------------------------
module mvsm_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            operation,
    input  wire logic [15:0]           sample_address,
    input  wire logic signed [15:0]    sample_value,
    input  wire logic [15:0]           voice_frames,
    input  wire logic                  voice_stereo,
    input  wire logic [17:0]           rate_step,
    input  wire mvsm_pkg::q_stat_t     q_stat,
    output logic                       push,
    output mvsm_pkg::cmd_t             push_cmd
);

    logic           valid_reg;
    logic           valid_next;
    mvsm_pkg::cmd_t cmd_reg;
    mvsm_pkg::op_t  kind;
    logic           accept;

    always_comb
    begin
        case (operation)
            mvsm_pkg::OP_TICK:  kind = mvsm_pkg::OP_TICK;
            mvsm_pkg::OP_START: kind = mvsm_pkg::OP_START;
            mvsm_pkg::OP_STOP:  kind = mvsm_pkg::OP_STOP;
            default:            kind = mvsm_pkg::OP_WRITE;
        endcase
    end

    assign push   = valid_reg && !q_stat.full;
    assign busy   = valid_reg && q_stat.full;
    assign accept = start && !busy;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.kind   <= kind;
            cmd_reg.addr   <= sample_address;
            cmd_reg.value  <= sample_value;
            cmd_reg.frames <= voice_frames;
            cmd_reg.stereo <= voice_stereo;
            cmd_reg.rate   <= rate_step;
        end
    end

    assign push_cmd = cmd_reg;

endmodule
`default_nettype wire

// ===== src/mvsm_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mvsm_queue
// Short command FIFO between the front register and the voice engine.
// ----------------------------------------------------------------------------
module mvsm_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire mvsm_pkg::cmd_t     push_cmd,
    input  wire logic               pop,
    output mvsm_pkg::q_stat_t       q_stat,
    output mvsm_pkg::cmd_t          head
);

    mvsm_pkg::cmd_t                   entry_reg [mvsm_pkg::QUEUE_DEPTH];
    logic [mvsm_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [mvsm_pkg::QUEUE_AW-1:0]    wr_ptr_next;
    logic [mvsm_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [mvsm_pkg::QUEUE_AW-1:0]    rd_ptr_next;
    logic [mvsm_pkg::QUEUE_CW-1:0]    count_reg;
    logic [mvsm_pkg::QUEUE_CW-1:0]    count_next;
    logic                             do_push;
    logic                             do_pop;

    localparam logic [mvsm_pkg::QUEUE_AW-1:0] LastPtr =
        mvsm_pkg::QUEUE_AW'(mvsm_pkg::QUEUE_DEPTH - 1);

    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = (count_reg == mvsm_pkg::QUEUE_CW'(mvsm_pkg::QUEUE_DEPTH));
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && q_stat.valid;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== src/mvsm_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mvsm_engine
// Voice engine: holds the voice table and the sample memory, executes one
// queued command at a time and walks the voices one by one on a tick.
// ----------------------------------------------------------------------------
module mvsm_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mvsm_pkg::q_stat_t  q_stat,
    input  wire mvsm_pkg::cmd_t     head,
    output logic                    pop,
    output logic                    done,
    output logic signed [15:0]      left_out,
    output logic signed [15:0]      right_out,
    output logic                    status,
    output logic [2:0]              voice_slot
);

    localparam int ACC_W = 16 + mvsm_pkg::VOICE_W + 2;
    localparam logic signed [ACC_W-1:0] MixMax = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] MixMin = ACC_W'(-32768);
    localparam logic [mvsm_pkg::VOICE_W-1:0] LastVoice =
        mvsm_pkg::VOICE_W'(mvsm_pkg::NUM_VOICES - 1);

    mvsm_pkg::eng_state_t state_reg;
    mvsm_pkg::eng_state_t state_next;

    // Voice table.
    logic [mvsm_pkg::NUM_VOICES-1:0] active_reg;
    logic [mvsm_pkg::NUM_VOICES-1:0] active_next;
    logic [16:0] pos_reg    [mvsm_pkg::NUM_VOICES];
    logic [15:0] frac_reg   [mvsm_pkg::NUM_VOICES];
    logic [17:0] rate_reg   [mvsm_pkg::NUM_VOICES];
    logic [15:0] base_reg   [mvsm_pkg::NUM_VOICES];
    logic [15:0] length_reg [mvsm_pkg::NUM_VOICES];
    logic        stereo_reg [mvsm_pkg::NUM_VOICES];

    logic [mvsm_pkg::VOICE_W-1:0] idx_reg;
    logic [mvsm_pkg::VOICE_W-1:0] idx_next;
    logic signed [ACC_W-1:0]      left_reg;
    logic signed [ACC_W-1:0]      left_next;
    logic signed [ACC_W-1:0]      right_reg;
    logic signed [ACC_W-1:0]      right_next;

    logic [15:0]                  sample_mem [mvsm_pkg::SAMPLE_WORDS];
    logic signed [15:0]           rd_data_reg;
    logic [mvsm_pkg::SAMPLE_AW-1:0] rd_addr;
    logic [mvsm_pkg::SAMPLE_AW-1:0] wr_addr;
    logic                         mem_we;

    logic                         done_reg;
    logic                         done_next;
    logic signed [15:0]           left_out_reg;
    logic signed [15:0]           left_out_next;
    logic signed [15:0]           right_out_reg;
    logic signed [15:0]           right_out_next;
    logic                         status_reg;
    logic                         status_next;
    logic [2:0]                   slot_reg;
    logic [2:0]                   slot_next;

    // Phase advance for the voice under the counter.
    logic [18:0]                  acc;
    logic [16:0]                  pos_new;
    logic                         retire;
    logic                         last;
    logic                         adv_we;

    // Free voice search for a start.
    logic                         free_found;
    logic [mvsm_pkg::VOICE_W-1:0] free_idx;
    logic                         start_we;
    logic [31:0]                  free_wide;

    logic [19:0]                  addr_first;
    logic [19:0]                  addr_second;

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        begin
            if (v > MixMax)
            begin
                c = MixMax;
            end
            else if (v < MixMin)
            begin
                c = MixMin;
            end
            else
            begin
                c = v;
            end
            sat16 = c[15:0];
        end
    endfunction

    assign acc     = 19'(frac_reg[idx_reg]) + 19'(rate_reg[idx_reg]);
    assign pos_new = pos_reg[idx_reg] + 17'(acc[18:16]);
    assign retire  = (pos_new >= 17'(length_reg[idx_reg]));
    assign last    = (idx_reg == LastVoice);

    assign addr_first = stereo_reg[idx_reg]
                      ? 20'(base_reg[idx_reg]) + 20'({pos_new, 1'b0})
                      : 20'(base_reg[idx_reg]) + 20'(pos_new);
    assign addr_second = 20'(base_reg[idx_reg]) + 20'({pos_reg[idx_reg], 1'b0}) + 20'd1;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int v = mvsm_pkg::NUM_VOICES - 1; v >= 0; v--)
        begin
            if (!active_reg[v])
            begin
                free_found = 1'b1;
                free_idx   = mvsm_pkg::VOICE_W'(v);
            end
        end
    end

    assign free_wide = 32'(free_idx);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mvsm_pkg::ST_IDLE:
            begin
                if (q_stat.valid && head.kind == mvsm_pkg::OP_TICK)
                begin
                    state_next = mvsm_pkg::ST_ADV;
                end
            end
            mvsm_pkg::ST_ADV:
            begin
                if (active_reg[idx_reg] && !retire)
                begin
                    state_next = mvsm_pkg::ST_RD1;
                end
                else if (last)
                begin
                    state_next = mvsm_pkg::ST_OUT;
                end
            end
            mvsm_pkg::ST_RD1:
            begin
                if (stereo_reg[idx_reg])
                begin
                    state_next = mvsm_pkg::ST_RD2;
                end
                else if (last)
                begin
                    state_next = mvsm_pkg::ST_OUT;
                end
                else
                begin
                    state_next = mvsm_pkg::ST_ADV;
                end
            end
            mvsm_pkg::ST_RD2:
            begin
                state_next = last ? mvsm_pkg::ST_OUT : mvsm_pkg::ST_ADV;
            end
            mvsm_pkg::ST_OUT:
            begin
                state_next = mvsm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mvsm_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath controls and results.
    always_comb
    begin
        pop            = 1'b0;
        active_next    = active_reg;
        idx_next       = idx_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        done_next      = 1'b0;
        left_out_next  = '0;
        right_out_next = '0;
        status_next    = 1'b0;
        slot_next      = '0;
        start_we       = 1'b0;
        adv_we         = 1'b0;
        mem_we         = 1'b0;
        wr_addr        = head.addr[mvsm_pkg::SAMPLE_AW-1:0];
        rd_addr        = addr_first[mvsm_pkg::SAMPLE_AW-1:0];
        case (state_reg)
            mvsm_pkg::ST_IDLE:
            begin
                if (q_stat.valid)
                begin
                    pop = 1'b1;
                    case (head.kind)
                        mvsm_pkg::OP_TICK:
                        begin
                            idx_next   = '0;
                            left_next  = '0;
                            right_next = '0;
                        end
                        mvsm_pkg::OP_START:
                        begin
                            done_next = 1'b1;
                            if (free_found)
                            begin
                                start_we              = 1'b1;
                                active_next[free_idx] = 1'b1;
                                slot_next             = free_wide[2:0];
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        mvsm_pkg::OP_STOP:
                        begin
                            done_next   = 1'b1;
                            active_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            mem_we    = 1'b1;
                        end
                    endcase
                end
            end
            mvsm_pkg::ST_ADV:
            begin
                if (active_reg[idx_reg])
                begin
                    adv_we = 1'b1;
                    if (retire)
                    begin
                        active_next[idx_reg] = 1'b0;
                    end
                end
                if ((!active_reg[idx_reg] || retire) && !last)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            mvsm_pkg::ST_RD1:
            begin
                left_next = left_reg + ACC_W'(rd_data_reg);
                rd_addr   = addr_second[mvsm_pkg::SAMPLE_AW-1:0];
                if (!stereo_reg[idx_reg])
                begin
                    right_next = right_reg + ACC_W'(rd_data_reg);
                    if (!last)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            mvsm_pkg::ST_RD2:
            begin
                right_next = right_reg + ACC_W'(rd_data_reg);
                if (!last)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            mvsm_pkg::ST_OUT:
            begin
                done_next      = 1'b1;
                left_out_next  = sat16(left_reg);
                right_out_next = sat16(right_reg);
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mvsm_pkg::ST_IDLE;
            active_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        if (start_we)
        begin
            base_reg[free_idx]   <= head.addr;
            length_reg[free_idx] <= head.frames;
            stereo_reg[free_idx] <= head.stereo;
            rate_reg[free_idx]   <= head.rate;
            pos_reg[free_idx]    <= '0;
            frac_reg[free_idx]   <= '0;
        end
        else if (adv_we)
        begin
            pos_reg[idx_reg]  <= pos_new;
            frac_reg[idx_reg] <= acc[15:0];
        end
    end

    // Sample memory: one write port for sample loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[wr_addr] <= head.value;
        end
        rd_data_reg <= sample_mem[rd_addr];
    end

    assign done       = done_reg;
    assign left_out   = left_out_reg;
    assign right_out  = right_out_reg;
    assign status     = status_reg;
    assign voice_slot = slot_reg;

endmodule
`default_nettype wire

// ===== src/multi_voice_sample_mixer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// Wavetable sound-effect mixer with a fixed set of voices and sample memory.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken at a rising edge with start high and busy low. Its
// operation selects tick, start voice, stop all voices or sample write.
// Every item produces exactly one result: done is high for one cycle with
// left_out, right_out, status and voice_slot valid in that cycle.
// Items pass an input register and a two-entry command queue before the
// voice engine, which registers each result, and the engine retires one
// start, stop or write item per cycle while no tick holds it.
// A tick is set up in the idle state and walks the voices one at a time:
// an idle or retiring voice passes only the advance state, a mono voice
// then reads one word and a stereo voice two words in turn (the sample
// memory has one read port), and the tick ends in an output state.
// busy rises while the input register holds an item and the queue is full.
// Reset clears all voices and the queue; sample memory keeps no reset value.
// Results cannot be held off, so done is never delayed by the receiver.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         operation,
    input  wire logic [15:0]        sample_address,
    input  wire logic signed [15:0] sample_value,
    input  wire logic [15:0]        voice_frames,
    input  wire logic               voice_stereo,
    input  wire logic [17:0]        rate_step,
    output logic                    done,
    output logic signed [15:0]      left_out,
    output logic signed [15:0]      right_out,
    output logic                    status,
    output logic [2:0]              voice_slot
);

    mvsm_pkg::q_stat_t q_stat;
    mvsm_pkg::cmd_t    push_cmd;
    mvsm_pkg::cmd_t    head;
    logic              push;
    logic              pop;

    mvsm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .sample_address (sample_address),
        .sample_value   (sample_value),
        .voice_frames   (voice_frames),
        .voice_stereo   (voice_stereo),
        .rate_step      (rate_step),
        .q_stat         (q_stat),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    mvsm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_stat   (q_stat),
        .head     (head)
    );

    mvsm_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .left_out   (left_out),
        .right_out  (right_out),
        .status     (status),
        .voice_slot (voice_slot)
    );

    // The front only hands over an item when the queue has room.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_stat.full)
        else $error("push into a full command queue");

    // busy only when the queue cannot take the held item.
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> q_stat.full)
        else $error("busy without a full queue");

    // A failed start reports no slot and no mix.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (voice_slot == 3'd0 && left_out == 16'sd0 &&
                              right_out == 16'sd0))
        else $error("failed start carries data");

    // The engine takes a new command only when the queue holds one.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_stat.valid)
        else $error("pop from an empty command queue");

endmodule
`default_nettype wire

// ===== tb/tb_multi_voice_sample_mixer.sv =====
// ----------------------------------------------------------------------------
// tb_multi_voice_sample_mixer
// Self-checking bench for the multi-voice sample mixer. A scoreboard class
// keeps its own copy of the voice registers and the sample memory, predicts
// the one result of every item the block takes, and compares each strobed
// result field by field. A short directed run covers address wrap, stereo,
// empty and stalled voices, the full voice set and stop-all. Random traffic
// then follows in phases with and without sender idle cycles.
// ----------------------------------------------------------------------------
module tb_multi_voice_sample_mixer;

    localparam int MIX_MAX          = 32767;
    localparam int MIX_MIN          = -32768;
    localparam int CYCLE_LIMIT      = 600000;
    localparam int RANDOM_PER_PHASE = 350;
    localparam int NUM_BANKS        = 6;

    typedef struct packed {
        logic signed [15:0] left_mix;
        logic signed [15:0] right_mix;
        logic               no_voice;
        logic [2:0]         slot;
    } mix_result_t;

    class mix_scoreboard;
        logic        active   [mvsm_pkg::NUM_VOICES];
        logic [16:0] position [mvsm_pkg::NUM_VOICES];
        logic [15:0] fraction [mvsm_pkg::NUM_VOICES];
        logic [17:0] step     [mvsm_pkg::NUM_VOICES];
        logic [15:0] base     [mvsm_pkg::NUM_VOICES];
        logic [15:0] length   [mvsm_pkg::NUM_VOICES];
        logic        stereo   [mvsm_pkg::NUM_VOICES];
        logic [15:0] samples  [mvsm_pkg::SAMPLE_WORDS];
        bit          written  [mvsm_pkg::SAMPLE_WORDS];
        mix_result_t pending[$];
        int          errors;
        int          n_items, n_ticks, n_starts, n_refused, n_retired;
        int          n_clipped, n_writes, n_stops;

        function new();
            for (int v = 0; v < mvsm_pkg::NUM_VOICES; v++)
            begin
                active[v]   = 1'b0;
                position[v] = '0;
                fraction[v] = '0;
                step[v]     = '0;
                base[v]     = '0;
                length[v]   = '0;
                stereo[v]   = 1'b0;
            end
            errors    = 0;
            n_items   = 0;
            n_ticks   = 0;
            n_starts  = 0;
            n_refused = 0;
            n_retired = 0;
            n_clipped = 0;
            n_writes  = 0;
            n_stops   = 0;
        endfunction

        // The phase moves on before the frame is read.
        function void advance(int v, output logic [16:0] pos, output logic [15:0] frac);
            logic [18:0] acc;
            acc  = {3'b000, fraction[v]} + {1'b0, step[v]};
            pos  = position[v] + {14'd0, acc[18:16]};
            frac = acc[15:0];
        endfunction

        // Memory words of one frame; a mono voice gives the same word to both sides.
        function void voice_words(int v, logic [16:0] pos, output logic [15:0] wl,
                                  output logic [15:0] wr);
            if (stereo[v])
            begin
                wl = base[v] + {pos[14:0], 1'b0};
                wr = wl + 16'd1;
            end
            else
            begin
                wl = base[v] + pos[15:0];
                wr = wl;
            end
        endfunction

        function logic signed [15:0] clip(int s);
            if (s > MIX_MAX)
            begin
                n_clipped++;
                return 16'sh7FFF;
            end
            if (s < MIX_MIN)
            begin
                n_clipped++;
                return 16'sh8000;
            end
            return 16'(s);
        endfunction

        // Words the next tick will read, so they can be written beforehand.
        function void tick_reads(output logic [15:0] addrs[$]);
            logic [16:0] pos;
            logic [15:0] frac, wl, wr;
            addrs = {};
            for (int v = 0; v < mvsm_pkg::NUM_VOICES; v++)
            begin
                if (active[v])
                begin
                    advance(v, pos, frac);
                    if (pos < {1'b0, length[v]})
                    begin
                        voice_words(v, pos, wl, wr);
                        addrs.push_back(wl);
                        addrs.push_back(wr);
                    end
                end
            end
        endfunction

        function void note_item(mvsm_pkg::cmd_t c);
            mix_result_t res;
            logic [16:0] pos;
            logic [15:0] frac, wl, wr;
            int          left_sum, right_sum, v;
            res = '0;
            n_items++;
            case (c.kind)
                mvsm_pkg::OP_TICK:
                begin
                    n_ticks++;
                    left_sum  = 0;
                    right_sum = 0;
                    for (v = 0; v < mvsm_pkg::NUM_VOICES; v++)
                    begin
                        if (active[v])
                        begin
                            advance(v, pos, frac);
                            position[v] = pos;
                            fraction[v] = frac;
                            if (pos >= {1'b0, length[v]})
                            begin
                                active[v] = 1'b0;
                                n_retired++;
                            end
                            else
                            begin
                                voice_words(v, pos, wl, wr);
                                left_sum  += int'($signed(samples[wl]));
                                right_sum += int'($signed(samples[wr]));
                            end
                        end
                    end
                    res.left_mix  = clip(left_sum);
                    res.right_mix = clip(right_sum);
                end
                mvsm_pkg::OP_START:
                begin
                    n_starts++;
                    for (v = 0; v < mvsm_pkg::NUM_VOICES; v++)
                        if (!active[v])
                            break;
                    if (v == mvsm_pkg::NUM_VOICES)
                    begin
                        res.no_voice = 1'b1;
                        n_refused++;
                    end
                    else
                    begin
                        base[v]     = c.addr;
                        length[v]   = c.frames;
                        stereo[v]   = c.stereo;
                        step[v]     = c.rate;
                        position[v] = '0;
                        fraction[v] = '0;
                        active[v]   = 1'b1;
                        res.slot    = 3'(v);
                    end
                end
                mvsm_pkg::OP_STOP:
                begin
                    n_stops++;
                    for (v = 0; v < mvsm_pkg::NUM_VOICES; v++)
                        active[v] = 1'b0;
                end
                mvsm_pkg::OP_WRITE:
                begin
                    n_writes++;
                    samples[c.addr] = c.value;
                    written[c.addr] = 1'b1;
                end
                default: ;
            endcase
            pending.push_back(res);
        endfunction

        function void check_result(mix_result_t got);
            mix_result_t want;
            if (pending.size() == 0)
            begin
                $error("result with no item waiting: left %0d right %0d",
                       got.left_mix, got.right_mix);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.left_mix !== want.left_mix)
            begin
                $error("left_out: expected %0d, got %0d", want.left_mix, got.left_mix);
                errors++;
            end
            if (got.right_mix !== want.right_mix)
            begin
                $error("right_out: expected %0d, got %0d", want.right_mix, got.right_mix);
                errors++;
            end
            if (got.no_voice !== want.no_voice)
            begin
                $error("status: expected %0d, got %0d", want.no_voice, got.no_voice);
                errors++;
            end
            if (got.slot !== want.slot)
            begin
                $error("voice_slot: expected %0d, got %0d", want.slot, got.slot);
                errors++;
            end
        endfunction
    endclass

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               start          = 1'b0;
    logic [1:0]         operation      = mvsm_pkg::OP_TICK;
    logic [15:0]        sample_address = '0;
    logic signed [15:0] sample_value   = '0;
    logic [15:0]        voice_frames   = '0;
    logic               voice_stereo   = 1'b0;
    logic [17:0]        rate_step      = '0;
    logic               busy;
    logic               done;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               status;
    logic [2:0]         voice_slot;

    mix_scoreboard board;
    int            idle_pct   = 0;
    int            n_sent     = 0;
    int            n_accepted = 0;
    int            cycles     = 0;

    multi_voice_sample_mixer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .sample_address (sample_address),
        .sample_value   (sample_value),
        .voice_frames   (voice_frames),
        .voice_stereo   (voice_stereo),
        .rate_step      (rate_step),
        .done           (done),
        .left_out       (left_out),
        .right_out      (right_out),
        .status         (status),
        .voice_slot     (voice_slot)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Results are checked before a newly taken item is noted.
    always @(posedge clk)
    begin : monitor
        mix_result_t    got;
        mvsm_pkg::cmd_t taken;
        if (rst_n)
        begin
            if (done)
            begin
                got.left_mix  = left_out;
                got.right_mix = right_out;
                got.no_voice  = status;
                got.slot      = voice_slot;
                board.check_result(got);
            end
            if (start && !busy)
            begin
                taken.kind   = mvsm_pkg::op_t'(operation);
                taken.addr   = sample_address;
                taken.value  = sample_value;
                taken.frames = voice_frames;
                taken.stereo = voice_stereo;
                taken.rate   = rate_step;
                board.note_item(taken);
                n_accepted++;
            end
        end
    end

    // Fields an operation does not use still carry random values.
    function automatic mvsm_pkg::cmd_t noise_cmd();
        mvsm_pkg::cmd_t c;
        c.kind   = mvsm_pkg::OP_TICK;
        c.addr   = 16'($urandom);
        c.value  = 16'($urandom);
        c.frames = 16'($urandom);
        c.stereo = 1'($urandom);
        c.rate   = 18'($urandom);
        return c;
    endfunction

    function automatic logic [15:0] loud_sample();
        case ($urandom_range(3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input mvsm_pkg::cmd_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        operation      <= c.kind;
        sample_address <= c.addr;
        sample_value   <= c.value;
        voice_frames   <= c.frames;
        voice_stereo   <= c.stereo;
        rate_step      <= c.rate;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_sent++;
        // The scoreboard must have seen this item before the next is planned.
        wait (n_accepted == n_sent);
    endtask

    task automatic do_write(input logic [15:0] addr, input logic [15:0] value);
        mvsm_pkg::cmd_t c;
        c       = noise_cmd();
        c.kind  = mvsm_pkg::OP_WRITE;
        c.addr  = addr;
        c.value = value;
        send_item(c);
    endtask

    task automatic do_start(input logic [15:0] addr, input logic [15:0] frames,
                            input logic two_ch, input logic [17:0] rate);
        mvsm_pkg::cmd_t c;
        c        = noise_cmd();
        c.kind   = mvsm_pkg::OP_START;
        c.addr   = addr;
        c.frames = frames;
        c.stereo = two_ch;
        c.rate   = rate;
        send_item(c);
    endtask

    task automatic do_stop();
        mvsm_pkg::cmd_t c;
        c      = noise_cmd();
        c.kind = mvsm_pkg::OP_STOP;
        send_item(c);
    endtask

    // Every word the tick is about to read that was never written gets written first.
    task automatic do_tick();
        logic [15:0]    need[$];
        mvsm_pkg::cmd_t c;
        board.tick_reads(need);
        foreach (need[i])
            if (!board.written[need[i]])
                do_write(need[i], loud_sample());
        c      = noise_cmd();
        c.kind = mvsm_pkg::OP_TICK;
        send_item(c);
    endtask

    initial
    begin : stimulus
        logic [15:0] bank [NUM_BANKS];
        logic [15:0] frames;
        logic [17:0] rate;
        logic [15:0] addr;
        int          r;
        int          phase_end;
        board   = new();
        bank[0] = 16'hFFF0;
        for (int i = 1; i < NUM_BANKS; i++)
            bank[i] = 16'($urandom);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        do_write(16'h0000, 16'h8000);
        do_write(16'hFFFF, 16'h7FFF);
        do_tick();
        do_start(16'hFFFF, 16'd3, 1'b0, 18'h10000);    // reads wrap past the top word
        do_start(16'h0100, 16'd2, 1'b1, 18'h08000);    // stereo at half speed
        do_start(16'h0200, 16'd0, 1'b0, 18'h10000);    // empty voice retires at once
        do_start(16'h0300, 16'd4, 1'b0, 18'h00000);    // stalled voice holds frame 0
        do_start(16'h8000, 16'hFFFF, 1'b1, 18'h3FFFF);
        for (int i = 1; i <= 3; i++)
            do_start(bank[i], 16'd8, i[0], 18'h18000);
        do_start(bank[4], 16'd8, 1'b0, 18'h10000);     // all voices are taken here
        repeat (4) do_tick();
        do_start(bank[5], 16'd1, 1'b0, 18'h10000);
        do_tick();
        do_stop();
        do_tick();

        // Each phase counts every item sent, the writes ahead of a tick included.
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = (p == 1) ? 77 : (p == 2) ? 10 : 0;
            phase_end = n_sent + RANDOM_PER_PHASE;
            while (n_sent < phase_end)
            begin
                r = $urandom_range(99);
                if (r < 45)
                    do_tick();
                else if (r < 72)
                begin
                    // Mostly short voices, so they retire and free their slots.
                    case ($urandom_range(19))
                        0:       frames = 16'($urandom_range(65535, 1));
                        1:       frames = 16'hFFFF;
                        default: frames = 16'($urandom_range(24, 1));
                    endcase
                    case ($urandom_range(9))
                        0:       rate = '0;
                        1:       rate = 18'h3FFFF;
                        2:       rate = 18'($urandom);
                        3, 4, 5: rate = 18'h10000;
                        default: rate = 18'($urandom_range(18'h1FFFF));
                    endcase
                    addr = ($urandom_range(4) == 0) ? 16'($urandom)
                                                     : bank[$urandom_range(NUM_BANKS - 1)];
                    do_start(addr, frames, 1'($urandom), rate);
                end
                else if (r < 77)
                    do_stop();
                else
                begin
                    addr = ($urandom_range(1) == 0) ? 16'($urandom)
                         : bank[$urandom_range(NUM_BANKS - 1)] + 16'($urandom_range(63));
                    do_write(addr, ($urandom_range(1) == 0) ? 16'($urandom) : loud_sample());
                end
            end
        end

        start <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (3 * mvsm_pkg::NUM_VOICES + 8) @(posedge clk);
        $display("Checked %0d items: %0d ticks, %0d starts (%0d found no free voice), %0d writes",
                 board.n_items, board.n_ticks, board.n_starts, board.n_refused, board.n_writes);
        $display("Voices retired: %0d, stop-all items: %0d, clipped channel mixes: %0d",
                 board.n_retired, board.n_stops, board.n_clipped);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
